### sv/i2ctmw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C target memory window package
// Shared constants: memory geometry, event codes, phases and register indexes.
// ----------------------------------------------------------------------------
package i2ctmw_pkg;

   localparam int MemDepth  = 256;
   localparam int AddrWidth = (MemDepth > 1) ? $clog2(MemDepth) : 1;

   localparam logic [31:0] MemDepthPtr = 32'(MemDepth);

   // bus and local event codes
   localparam logic [2:0] ModeAddrWrite = 3'd0;
   localparam logic [2:0] ModeAddrRead  = 3'd1;
   localparam logic [2:0] ModeRxByte    = 3'd2;
   localparam logic [2:0] ModeTxRequest = 3'd3;
   localparam logic [2:0] ModeLocalWr   = 3'd4;
   localparam logic [2:0] ModeLocalRd   = 3'd5;

   // pointer reception phases
   localparam logic [2:0] PhaseCommand = 3'd0;
   localparam logic [2:0] PhaseByte0   = 3'd1;
   localparam logic [2:0] PhaseByte1   = 3'd2;
   localparam logic [2:0] PhaseByte2   = 3'd3;
   localparam logic [2:0] PhaseByte3   = 3'd4;
   localparam logic [2:0] PhaseDone    = 3'd5;

   // register indexes
   localparam logic [1:0] RegLinked     = 2'd0;
   localparam logic [1:0] RegDataSize   = 2'd1;
   localparam logic [1:0] RegCmdSetAddr = 2'd2;
   localparam logic [1:0] RegCmdRdHere  = 2'd3;

   localparam logic [7:0] CmdSetAddrReset = 8'd1;
   localparam logic [7:0] CmdRdHereReset  = 8'd2;

endpackage
`default_nettype wire

### sv/i2ctmw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module i2ctmw_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                       rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### sv/i2c_target_memory_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C target memory window
// Byte-level event handler of an I2C target exposing a byte memory window.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while req_stall is low; its result goes
// through the registered read of the window RAM and then the output register.
// Phase, pointer and memory are updated at the transfer edge, so back-to-back
// events see each other's effects. The memory reads as zero after reset
// through one valid flag per entry, so no clearing pass is needed. The
// configuration port is always ready; the user is to write registers only
// while no event is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module i2c_target_memory_window (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_local_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_tx_from_memory,
   output logic [7:0]       rsp_local_data,
   output logic [31:0]      rsp_current_pointer,
   output logic             rsp_pointer_complete,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int AW = i2ctmw_pkg::AddrWidth;

   // configuration
   logic       linked_ff;
   logic [8:0] window_size_ff;
   logic [7:0] cmd_set_ff;
   logic [7:0] cmd_here_ff;

   // event state
   logic [31:0] pointer_ff, pointer_in;
   logic [2:0]  phase_ff, phase_in;
   logic [i2ctmw_pkg::MemDepth-1:0] valid_ff;

   // memory access
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   // stage one: memory read in flight
   logic        s1_valid_ff;
   logic        s1_tx_ff, s1_tx_in;
   logic        s1_local_ff, s1_local_in;
   logic        s1_hit_ff;
   logic [31:0] s1_pointer_ff;
   logic        s1_done_ff;

   logic accept, s1_move, cfg_write;

   logic [31:0] tx_ptr;
   logic        tx_in_window, rx_in_window;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   assign s1_move   = s1_valid_ff && !(rsp_valid && rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign tx_ptr = (phase_ff != i2ctmw_pkg::PhaseDone) ? 32'd0 : pointer_ff;
   assign tx_in_window = linked_ff && (tx_ptr < 32'(window_size_ff)) &&
                         (tx_ptr < i2ctmw_pkg::MemDepthPtr);
   assign rx_in_window = linked_ff && (pointer_ff < 32'(window_size_ff)) &&
                         (pointer_ff < i2ctmw_pkg::MemDepthPtr);

   always_comb begin
      pointer_in  = pointer_ff;
      phase_in    = phase_ff;
      mem_we      = 1'b0;
      mem_waddr   = req_local_address[AW-1:0];
      mem_wdata   = req_data_byte;
      mem_re      = 1'b0;
      mem_raddr   = req_local_address[AW-1:0];
      s1_tx_in    = 1'b0;
      s1_local_in = 1'b0;
      if (accept) begin
         unique case (req_mode)
            i2ctmw_pkg::ModeAddrWrite: begin
               phase_in = i2ctmw_pkg::PhaseCommand;
            end
            i2ctmw_pkg::ModeAddrRead, i2ctmw_pkg::ModeTxRequest: begin
               phase_in   = i2ctmw_pkg::PhaseDone;
               pointer_in = tx_ptr;
               if (tx_in_window) begin
                  mem_re     = 1'b1;
                  mem_raddr  = tx_ptr[AW-1:0];
                  s1_tx_in   = 1'b1;
                  pointer_in = tx_ptr + 32'd1;
               end
            end
            i2ctmw_pkg::ModeRxByte: begin
               if (phase_ff == i2ctmw_pkg::PhaseCommand) begin
                  // read-here wins when both codes match
                  if (req_data_byte == cmd_here_ff) begin
                     phase_in = i2ctmw_pkg::PhaseDone;
                  end else if (req_data_byte == cmd_set_ff) begin
                     phase_in = i2ctmw_pkg::PhaseByte0;
                  end
               end else if (linked_ff) begin
                  if (phase_ff == i2ctmw_pkg::PhaseDone) begin
                     if (rx_in_window) begin
                        mem_we     = 1'b1;
                        mem_waddr  = pointer_ff[AW-1:0];
                        pointer_in = pointer_ff + 32'd1;
                     end
                  end else if (phase_ff < i2ctmw_pkg::PhaseDone) begin
                     phase_in = phase_ff + 3'd1;
                     unique case (phase_ff)
                        i2ctmw_pkg::PhaseByte0: pointer_in[7:0]   = req_data_byte;
                        i2ctmw_pkg::PhaseByte1: pointer_in[15:8]  = req_data_byte;
                        i2ctmw_pkg::PhaseByte2: pointer_in[23:16] = req_data_byte;
                        default:                pointer_in[31:24] = req_data_byte;
                     endcase
                  end
               end
            end
            i2ctmw_pkg::ModeLocalWr: begin
               if (32'(req_local_address) < i2ctmw_pkg::MemDepthPtr) begin
                  mem_we = 1'b1;
               end
            end
            i2ctmw_pkg::ModeLocalRd: begin
               if (32'(req_local_address) < i2ctmw_pkg::MemDepthPtr) begin
                  mem_re      = 1'b1;
                  s1_local_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // a window size write clears the pointer
      if (cfg_write && csr_index == i2ctmw_pkg::RegDataSize) begin
         pointer_in = 32'd0;
      end
   end

   i2ctmw_ram #(
      .Width (8),
      .Depth (i2ctmw_pkg::MemDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff      <= 1'b0;
         window_size_ff <= 9'd0;
         cmd_set_ff     <= i2ctmw_pkg::CmdSetAddrReset;
         cmd_here_ff    <= i2ctmw_pkg::CmdRdHereReset;
      end else if (cfg_write) begin
         unique case (csr_index)
            i2ctmw_pkg::RegLinked:     linked_ff      <= csr_data[0];
            i2ctmw_pkg::RegDataSize:   window_size_ff <= csr_data;
            i2ctmw_pkg::RegCmdSetAddr: cmd_set_ff     <= csr_data[7:0];
            default:                   cmd_here_ff    <= csr_data[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= 32'd0;
         phase_ff   <= i2ctmw_pkg::PhaseCommand;
         valid_ff   <= '0;
      end else begin
         pointer_ff <= pointer_in;
         phase_ff   <= phase_in;
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   // stage one holds while the output is stalled; the RAM read data holds too
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tx_ff      <= s1_tx_in;
         s1_local_ff   <= s1_local_in;
         s1_hit_ff     <= valid_ff[mem_raddr];
         s1_pointer_ff <= pointer_in;
         s1_done_ff    <= (phase_in == i2ctmw_pkg::PhaseDone);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s1_move) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_tx_byte          <= (s1_tx_ff && s1_hit_ff) ? mem_rdata : 8'd0;
         rsp_tx_from_memory   <= s1_tx_ff;
         rsp_local_data       <= (s1_local_ff && s1_hit_ff) ? mem_rdata : 8'd0;
         rsp_current_pointer  <= s1_pointer_ff;
         rsp_pointer_complete <= s1_done_ff;
      end
   end

endmodule
`default_nettype wire

### sv/i2ctmw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C target memory window checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module i2ctmw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_tx_from_memory,
   input wire logic [7:0]  rsp_local_data,
   input wire logic [31:0] rsp_current_pointer,
   input wire logic        rsp_pointer_complete
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_current_pointer) &&
         $stable(rsp_tx_byte) && $stable(rsp_local_data))
      else $error("stalled result changed");

   a_filler_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_from_memory |-> rsp_tx_byte == 8'd0)
      else $error("filler byte is not zero");

   // a transfer is either a bus transmit or a local read, never both
   a_tx_local_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_from_memory |-> rsp_local_data == 8'd0)
      else $error("transmit and local read in one result");

   a_tx_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_from_memory |-> rsp_pointer_complete &&
         rsp_current_pointer != 32'd0)
      else $error("transmit without complete pointer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind i2c_target_memory_window i2ctmw_checker u_checker (.*);
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: I2C target memory window
// Drives bus events and local memory accesses with random gaps and random
// result stalls, tracks the window state alongside the block and checks each
// result transfer field by field against the tracked state.
// ----------------------------------------------------------------------------
module tb;

   localparam int IdleLimit = 2000;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_from_memory;
      logic [7:0]  local_data;
      logic [31:0] current_pointer;
      logic        pointer_complete;
   } window_result_type;

   typedef enum int {StallNone, StallLight, StallPeriodic, StallHeavy} stall_style_type;

   class window_scoreboard_type;
      bit [7:0]          window_mem [i2ctmw_pkg::MemDepth];
      bit [31:0]         pointer;
      bit [2:0]          phase;
      bit                linked;
      bit [8:0]          window_size;
      bit [7:0]          cmd_set_addr = i2ctmw_pkg::CmdSetAddrReset;
      bit [7:0]          cmd_rd_here  = i2ctmw_pkg::CmdRdHereReset;
      window_result_type awaited [$];
      int                errors;

      function bit in_window();
         return linked && pointer < 32'(window_size) &&
                pointer < i2ctmw_pkg::MemDepthPtr;
      endfunction

      function void apply_register(logic [1:0] idx, logic [8:0] val);
         case (idx)
            i2ctmw_pkg::RegLinked: linked = val[0];
            i2ctmw_pkg::RegDataSize: begin
               window_size = val;
               pointer     = '0;
            end
            i2ctmw_pkg::RegCmdSetAddr: cmd_set_addr = val[7:0];
            i2ctmw_pkg::RegCmdRdHere: cmd_rd_here = val[7:0];
            default: ;
         endcase
      endfunction

      function void predict_event(bit [2:0] m, bit [7:0] b, bit [7:0] la);
         window_result_type r;
         r = '0;
         case (m)
            i2ctmw_pkg::ModeAddrWrite: phase = i2ctmw_pkg::PhaseCommand;
            i2ctmw_pkg::ModeAddrRead, i2ctmw_pkg::ModeTxRequest: begin
               // an incomplete pointer restarts at the window base
               if (phase != i2ctmw_pkg::PhaseDone) begin
                  phase   = i2ctmw_pkg::PhaseDone;
                  pointer = '0;
               end
               if (in_window()) begin
                  r.tx_byte        = window_mem[pointer[i2ctmw_pkg::AddrWidth-1:0]];
                  r.tx_from_memory = 1'b1;
                  pointer          = pointer + 32'd1;
               end
            end
            i2ctmw_pkg::ModeRxByte: begin
               if (phase == i2ctmw_pkg::PhaseCommand) begin
                  if (b == cmd_set_addr) phase = i2ctmw_pkg::PhaseByte0;
                  if (b == cmd_rd_here) phase = i2ctmw_pkg::PhaseDone;
               end else if (linked) begin
                  if (phase < i2ctmw_pkg::PhaseDone) begin
                     pointer[8 * (phase - 1) +: 8] = b;
                     phase = phase + 3'd1;
                  end else if (in_window()) begin
                     window_mem[pointer[i2ctmw_pkg::AddrWidth-1:0]] = b;
                     pointer = pointer + 32'd1;
                  end
               end
            end
            i2ctmw_pkg::ModeLocalWr: window_mem[la] = b;
            i2ctmw_pkg::ModeLocalRd: r.local_data = window_mem[la];
            default: ;
         endcase
         r.current_pointer  = pointer;
         r.pointer_complete = (phase == i2ctmw_pkg::PhaseDone);
         awaited.push_back(r);
      endfunction

      function void check_result(window_result_type got);
         window_result_type e;
         if (awaited.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (got.tx_byte !== e.tx_byte) begin
            $error("tx_byte: expected %0h, actual %0h", e.tx_byte, got.tx_byte);
            errors++;
         end
         if (got.tx_from_memory !== e.tx_from_memory) begin
            $error("tx_from_memory: expected %0h, actual %0h",
                   e.tx_from_memory, got.tx_from_memory);
            errors++;
         end
         if (got.local_data !== e.local_data) begin
            $error("local_data: expected %0h, actual %0h", e.local_data, got.local_data);
            errors++;
         end
         if (got.current_pointer !== e.current_pointer) begin
            $error("current_pointer: expected %0h, actual %0h",
                   e.current_pointer, got.current_pointer);
            errors++;
         end
         if (got.pointer_complete !== e.pointer_complete) begin
            $error("pointer_complete: expected %0h, actual %0h",
                   e.pointer_complete, got.pointer_complete);
            errors++;
         end
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic [2:0]  req_mode          = '0;
   logic [7:0]  req_data_byte     = '0;
   logic [7:0]  req_local_address = '0;
   logic        rsp_stall         = 1'b0;
   logic        csr_valid         = 1'b0;
   logic [1:0]  csr_index         = '0;
   logic [8:0]  csr_data          = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_from_memory;
   logic [7:0]  rsp_local_data;
   logic [31:0] rsp_current_pointer;
   logic        rsp_pointer_complete;
   logic        csr_ready;

   window_scoreboard_type sb;
   int                    burst_left;
   int                    items_sent;
   int                    idle_cycles;
   int                    stall_left;
   int                    cycle_count;
   stall_style_type       stall_style;

   i2c_target_memory_window DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_data_byte        (req_data_byte),
      .req_local_address    (req_local_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_tx_byte          (rsp_tx_byte),
      .rsp_tx_from_memory   (rsp_tx_from_memory),
      .rsp_local_data       (rsp_local_data),
      .rsp_current_pointer  (rsp_current_pointer),
      .rsp_pointer_complete (rsp_pointer_complete),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: switch stall behavior every so often
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(16, 128);
      end
      stall_left--;
      cycle_count++;
      case (stall_style)
         StallNone: rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 99) < 30);
         StallPeriodic: rsp_stall <= cycle_count[1];
         default: rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   always @(posedge clock) begin
      window_result_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            sb.predict_event(req_mode, req_data_byte, req_local_address);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_tx_byte, rsp_tx_from_memory, rsp_local_data,
                    rsp_current_pointer, rsp_pointer_complete};
            sb.check_result(got);
            idle_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            sb.apply_register(csr_index, csr_data);
            idle_cycles = 0;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_event(input logic [2:0] m, input logic [7:0] b,
                             input logic [7:0] la);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_data_byte     <= b;
      req_local_address <= la;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // drain all results before touching a register
   task automatic write_register(input logic [1:0] idx, input logic [8:0] val);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  <= 1'b0;
      burst_left = 0;
   endtask

   task automatic set_pointer(input logic [31:0] p);
      send_event(i2ctmw_pkg::ModeAddrWrite, 8'($urandom), 8'($urandom));
      send_event(i2ctmw_pkg::ModeRxByte, sb.cmd_set_addr, 8'($urandom));
      for (int i = 0; i < 4; i++) begin
         send_event(i2ctmw_pkg::ModeRxByte, p[8 * i +: 8], 8'($urandom));
      end
   endtask

   task automatic random_sequence();
      int          pick;
      logic [31:0] target;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 8) target = $urandom_range(0, sb.window_size + 3);
      else target = $urandom;
      if (pick < 35) begin
         set_pointer(target);
         repeat ($urandom_range(0, 8)) begin
            send_event(i2ctmw_pkg::ModeRxByte, 8'($urandom), 8'($urandom));
         end
      end else if (pick < 60) begin
         case ($urandom_range(0, 2))
            0: set_pointer(target);
            1: begin
               send_event(i2ctmw_pkg::ModeAddrWrite, 8'($urandom), 8'($urandom));
               send_event(i2ctmw_pkg::ModeRxByte, sb.cmd_rd_here, 8'($urandom));
            end
            default: ;
         endcase
         send_event(i2ctmw_pkg::ModeAddrRead, 8'($urandom), 8'($urandom));
         repeat ($urandom_range(0, 6)) begin
            send_event(i2ctmw_pkg::ModeTxRequest, 8'($urandom), 8'($urandom));
         end
      end else if (pick < 75) begin
         repeat ($urandom_range(1, 4)) begin
            send_event($urandom_range(0, 1) ? i2ctmw_pkg::ModeLocalWr :
                       i2ctmw_pkg::ModeLocalRd, 8'($urandom), 8'($urandom));
         end
      end else if (pick < 85) begin
         // cut the pointer short, then carry on with anything
         send_event(i2ctmw_pkg::ModeAddrWrite, 8'($urandom), 8'($urandom));
         send_event(i2ctmw_pkg::ModeRxByte, sb.cmd_set_addr, 8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            send_event(i2ctmw_pkg::ModeRxByte, 8'($urandom), 8'($urandom));
         end
         send_event(3'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            send_event(3'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      int         phase_end;
      logic       linked_v;
      logic [8:0] size_v;
      logic [7:0] set_v;
      logic [7:0] rd_v;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window detached, default command codes
      send_event(i2ctmw_pkg::ModeLocalWr, 8'hFF, 8'hFF);
      send_event(i2ctmw_pkg::ModeLocalWr, 8'hA5, 8'h00);
      send_event(i2ctmw_pkg::ModeLocalRd, 8'h00, 8'hFF);
      send_event(i2ctmw_pkg::ModeLocalRd, 8'hFF, 8'h00);
      send_event(3'd6, 8'h5A, 8'h3C);
      send_event(3'd7, 8'hC3, 8'h81);
      send_event(i2ctmw_pkg::ModeTxRequest, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeAddrWrite, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, 8'h77, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, i2ctmw_pkg::CmdSetAddrReset, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, 8'h12, 8'h00);

      // attach the full window: fill its top end and run off it
      write_register(i2ctmw_pkg::RegLinked, 9'd1);
      write_register(i2ctmw_pkg::RegDataSize, 9'd256);
      set_pointer(32'h0000_00FE);
      send_event(i2ctmw_pkg::ModeRxByte, 8'h5A, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, 8'hC3, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, 8'h11, 8'h00);
      send_event(i2ctmw_pkg::ModeAddrRead, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeAddrWrite, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeRxByte, i2ctmw_pkg::CmdRdHereReset, 8'h00);
      send_event(i2ctmw_pkg::ModeAddrWrite, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeAddrRead, 8'h00, 8'h00);
      send_event(i2ctmw_pkg::ModeTxRequest, 8'h00, 8'h00);

      for (int k = 0; k < 8; k++) begin
         linked_v = 1'b1;
         size_v   = 9'($urandom_range(1, 256));
         set_v    = 8'($urandom);
         rd_v     = 8'($urandom);
         case (k)
            0: begin
               size_v = 9'd256;
               set_v  = 8'h00;
               rd_v   = 8'hFF;
            end
            1: begin
               size_v = 9'd0;
               set_v  = 8'hFF;
               rd_v   = 8'h00;
            end
            2: linked_v = 1'b0;
            3: rd_v = set_v;
            default: if ($urandom_range(0, 3) == 0) size_v = 9'($urandom_range(1, 8));
         endcase
         write_register(i2ctmw_pkg::RegLinked, {8'b0, linked_v});
         write_register(i2ctmw_pkg::RegDataSize, size_v);
         write_register(i2ctmw_pkg::RegCmdSetAddr, {1'b0, set_v});
         write_register(i2ctmw_pkg::RegCmdRdHere, {1'b0, rd_v});
         phase_end = items_sent + 55;
         while (items_sent < phase_end) random_sequence();
      end

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
sv/i2ctmw_pkg.sv
sv/i2ctmw_ram.sv
sv/i2c_target_memory_window.sv
sv/i2ctmw_checker.sv
test/tb.sv
